// ----- src/dstq_pkg.sv -----
// Shared types and constants for the deadline sorted timer queue.
// Holds store sizes, action and result codes, micro-ops and the
// sequencer/datapath control and status structs. No dependencies.
package dstq_pkg;

   localparam int DEPTH       = 16;
   localparam int MAX_RESULTS = 16;

   localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int NRES_W = $clog2(MAX_RESULTS + 1);
   localparam int TIME_W = 32;
   localparam int DLY_W  = 31;
   localparam int TAG_W  = 16;
   localparam int PC_W   = 5;

   // Input item actions
   typedef enum logic [1:0] {
      ACT_ADD   = 2'd0,
      ACT_TICK  = 2'd1,
      ACT_CHECK = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_ACCEPTED = 2'd0,
      KIND_REJECTED = 2'd1,
      KIND_EXPIRED  = 2'd2,
      KIND_UNUSED   = 2'd3
   } kind_type;

   // Datapath operations, one per microcode step
   typedef enum logic [3:0] {
      OP_NOP,
      OP_ACCEPT,
      OP_TICK,
      OP_SCAN_RD,
      OP_INC_IDX,
      OP_SET_POS,
      OP_SH_RD,
      OP_SH_WR,
      OP_PUT,
      OP_EMIT_ACC,
      OP_EMIT_REJ,
      OP_HEAD_RD,
      OP_POP,
      OP_EMIT_LAST
   } op_type;

   // Jump conditions
   typedef enum logic [3:0] {
      C_NEVER,
      C_ALWAYS,
      C_NOT_REQ,
      C_ACT_ADD,
      C_ACT_TICK,
      C_ACT_CHECK,
      C_FULL,
      C_SCAN_DONE,
      C_NOT_BEFORE,
      C_SHIFT_DONE,
      C_CHK_STOP,
      C_NOT_DUE,
      C_NO_PEND
   } cond_type;

   typedef struct packed {
      op_type           op;
      cond_type         cond;
      logic [PC_W-1:0]  target;
   } uword_type;

   typedef struct packed {
      op_type op;
   } ctrl_type;

   typedef struct packed {
      logic       req_fire;
      action_type act;
      logic       full;
      logic       scan_done;
      logic       rd_before;
      logic       shift_done;
      logic       chk_stop;
      logic       not_due;
      logic       has_pend;
      logic       stall;
   } status_type;

   // a strictly before b, by modular difference
   function automatic logic is_before(input logic [TIME_W-1:0] a,
                                      input logic [TIME_W-1:0] b);
      logic [TIME_W-1:0] diff;
      diff = a - b;
      return diff[TIME_W-1];
   endfunction

endpackage

// ----- src/dstq_seq.sv -----
// Microcode sequencer: step counter, control store and jump logic.
// Depends on dstq_pkg for the control word, op and condition types.
module dstq_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  dstq_pkg::status_type status,
   output dstq_pkg::ctrl_type   ctrl
);
   import dstq_pkg::*;

   // Program labels
   localparam logic [PC_W-1:0] L_FETCH = 5'd0;
   localparam logic [PC_W-1:0] L_TICK  = 5'd5;
   localparam logic [PC_W-1:0] L_ADD   = 5'd6;
   localparam logic [PC_W-1:0] L_SCAN  = 5'd7;
   localparam logic [PC_W-1:0] L_INS   = 5'd10;
   localparam logic [PC_W-1:0] L_SHIFT = 5'd11;
   localparam logic [PC_W-1:0] L_PUT   = 5'd14;
   localparam logic [PC_W-1:0] L_REJ   = 5'd16;
   localparam logic [PC_W-1:0] L_CHK   = 5'd17;
   localparam logic [PC_W-1:0] L_FIN   = 5'd21;

   function automatic uword_type ucode(input logic [PC_W-1:0] addr);
      uword_type w;
      w = '{op: OP_NOP, cond: C_ALWAYS, target: L_FETCH};
      case (addr)
         // fetch and dispatch
         5'd0:  w = '{op: OP_ACCEPT,    cond: C_NOT_REQ,    target: L_FETCH};
         5'd1:  w = '{op: OP_NOP,       cond: C_ACT_TICK,   target: L_TICK};
         5'd2:  w = '{op: OP_NOP,       cond: C_ACT_CHECK,  target: L_CHK};
         5'd3:  w = '{op: OP_NOP,       cond: C_ACT_ADD,    target: L_ADD};
         5'd4:  w = '{op: OP_NOP,       cond: C_ALWAYS,     target: L_FETCH};
         // tick
         5'd5:  w = '{op: OP_TICK,      cond: C_ALWAYS,     target: L_FETCH};
         // add: find position
         5'd6:  w = '{op: OP_NOP,       cond: C_FULL,       target: L_REJ};
         5'd7:  w = '{op: OP_SCAN_RD,   cond: C_SCAN_DONE,  target: L_INS};
         5'd8:  w = '{op: OP_NOP,       cond: C_NOT_BEFORE, target: L_INS};
         5'd9:  w = '{op: OP_INC_IDX,   cond: C_ALWAYS,     target: L_SCAN};
         // add: open a slot and store
         5'd10: w = '{op: OP_SET_POS,   cond: C_NEVER,      target: L_FETCH};
         5'd11: w = '{op: OP_NOP,       cond: C_SHIFT_DONE, target: L_PUT};
         5'd12: w = '{op: OP_SH_RD,     cond: C_NEVER,      target: L_FETCH};
         5'd13: w = '{op: OP_SH_WR,     cond: C_ALWAYS,     target: L_SHIFT};
         5'd14: w = '{op: OP_PUT,       cond: C_NEVER,      target: L_FETCH};
         5'd15: w = '{op: OP_EMIT_ACC,  cond: C_ALWAYS,     target: L_FETCH};
         5'd16: w = '{op: OP_EMIT_REJ,  cond: C_ALWAYS,     target: L_FETCH};
         // check: pop due head entries
         5'd17: w = '{op: OP_NOP,       cond: C_CHK_STOP,   target: L_FIN};
         5'd18: w = '{op: OP_HEAD_RD,   cond: C_NEVER,      target: L_FETCH};
         5'd19: w = '{op: OP_NOP,       cond: C_NOT_DUE,    target: L_FIN};
         5'd20: w = '{op: OP_POP,       cond: C_ALWAYS,     target: L_CHK};
         5'd21: w = '{op: OP_NOP,       cond: C_NO_PEND,    target: L_FETCH};
         5'd22: w = '{op: OP_EMIT_LAST, cond: C_ALWAYS,     target: L_FETCH};
         default: w = '{op: OP_NOP,     cond: C_ALWAYS,     target: L_FETCH};
      endcase
      return w;
   endfunction

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uw;
   logic            take;

   assign uw      = ucode(pc_ff);
   assign ctrl.op = uw.op;

   // Evaluate the jump condition
   always_comb begin
      unique case (uw.cond)
         C_NEVER:      take = 1'b0;
         C_ALWAYS:     take = 1'b1;
         C_NOT_REQ:    take = !status.req_fire;
         C_ACT_ADD:    take = (status.act == ACT_ADD);
         C_ACT_TICK:   take = (status.act == ACT_TICK);
         C_ACT_CHECK:  take = (status.act == ACT_CHECK);
         C_FULL:       take = status.full;
         C_SCAN_DONE:  take = status.scan_done;
         C_NOT_BEFORE: take = !status.rd_before;
         C_SHIFT_DONE: take = status.shift_done;
         C_CHK_STOP:   take = status.chk_stop;
         C_NOT_DUE:    take = status.not_due;
         C_NO_PEND:    take = !status.has_pend;
         default:      take = 1'b0;
      endcase
   end

   // Hold on a stalled emit, else jump or advance
   always_comb begin
      if (status.stall) begin
         pc_in = pc_ff;
      end else if (take) begin
         pc_in = uw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= L_FETCH;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ----- src/dstq_dp.sv -----
// Datapath: entry memories (circular, head pointer), time counter,
// scan index, pending expire and the result register.
// Depends on dstq_pkg; driven by the op from dstq_seq.
module dstq_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  dstq_pkg::ctrl_type             ctrl,
   output dstq_pkg::status_type           status,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [1:0]                     req_action,
   input  logic [dstq_pkg::DLY_W-1:0]     req_delay,
   input  logic [dstq_pkg::TAG_W-1:0]     req_tag,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [1:0]                     rsp_kind,
   output logic [dstq_pkg::TAG_W-1:0]     rsp_tag,
   output logic                           rsp_last
);
   import dstq_pkg::*;

   logic [TIME_W-1:0] dl_mem  [DEPTH];
   logic [TAG_W-1:0]  tag_mem [DEPTH];

   logic [TIME_W-1:0] now_ff, now_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  pos_ff, pos_in;
   logic [NRES_W-1:0] nres_ff, nres_in;
   action_type        act_ff, act_in;
   logic [TIME_W-1:0] dl_ff, dl_in;
   logic [TAG_W-1:0]  tag_ff, tag_in;
   logic              pend_v_ff, pend_v_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic [TIME_W-1:0] rd_dl_ff;
   logic [TAG_W-1:0]  rd_tag_ff;

   logic              out_v_ff, out_v_in;
   kind_type          out_kind_ff, out_kind_in;
   logic [TAG_W-1:0]  out_tag_ff, out_tag_in;
   logic              out_last_ff, out_last_in;

   logic              req_fire;
   logic              emit_req;
   logic              stall;
   logic              go;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [TIME_W-1:0] wr_dl;
   logic [TAG_W-1:0]  wr_tag;
   logic [CNT_W-1:0]  idx_dec;

   // Map a logical index onto a memory address past the head
   function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                             input logic [CNT_W-1:0] idx);
      logic [IDX_W:0] sum;
      sum = {1'b0, head} + {1'b0, idx[IDX_W-1:0]};
      if (sum >= (IDX_W+1)'(DEPTH)) begin
         sum = sum - (IDX_W+1)'(DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign req_tready = (ctrl.op == OP_ACCEPT);
   assign req_fire   = req_tvalid && req_tready;
   assign idx_dec    = idx_ff - 1'b1;

   // Emits wait for a free result register
   assign emit_req = (ctrl.op == OP_EMIT_ACC) || (ctrl.op == OP_EMIT_REJ) ||
                     (ctrl.op == OP_EMIT_LAST) || ((ctrl.op == OP_POP) && pend_v_ff);
   assign stall    = emit_req && out_v_ff && !rsp_tready;
   assign go       = !stall;

   // Status toward the sequencer
   always_comb begin
      status.req_fire   = req_fire;
      status.act        = act_ff;
      status.full       = (cnt_ff == CNT_W'(DEPTH));
      status.scan_done  = (idx_ff == cnt_ff);
      status.rd_before  = is_before(rd_dl_ff, dl_ff);
      status.shift_done = (idx_ff == pos_ff);
      status.chk_stop   = (cnt_ff == '0) || (nres_ff == NRES_W'(MAX_RESULTS));
      status.not_due    = is_before(now_ff, rd_dl_ff);
      status.has_pend   = pend_v_ff;
      status.stall      = stall;
   end

   // Memory read and write addresses
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = head_ff;
      wr_en   = 1'b0;
      wr_addr = phys(head_ff, idx_ff);
      wr_dl   = rd_dl_ff;
      wr_tag  = rd_tag_ff;
      case (ctrl.op)
         OP_SCAN_RD: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, idx_ff);
         end
         OP_SH_RD: begin
            rd_en   = 1'b1;
            rd_addr = phys(head_ff, idx_dec);
         end
         OP_HEAD_RD: begin
            rd_en   = 1'b1;
            rd_addr = head_ff;
         end
         OP_SH_WR: begin
            wr_en = 1'b1;
         end
         OP_PUT: begin
            wr_en   = 1'b1;
            wr_addr = phys(head_ff, pos_ff);
            wr_dl   = dl_ff;
            wr_tag  = tag_ff;
         end
         default: begin
         end
      endcase
   end

   // Entry memories, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         dl_mem[wr_addr]  <= wr_dl;
         tag_mem[wr_addr] <= wr_tag;
      end
      if (rd_en) begin
         rd_dl_ff  <= dl_mem[rd_addr];
         rd_tag_ff <= tag_mem[rd_addr];
      end
   end

   // Datapath register updates
   always_comb begin
      now_in      = now_ff;
      cnt_in      = cnt_ff;
      head_in     = head_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      nres_in     = nres_ff;
      act_in      = act_ff;
      dl_in       = dl_ff;
      tag_in      = tag_ff;
      pend_v_in   = pend_v_ff;
      pend_tag_in = pend_tag_ff;
      case (ctrl.op)
         OP_ACCEPT: begin
            if (req_fire) begin
               act_in    = action_type'(req_action);
               dl_in     = now_ff + {1'b0, req_delay};
               tag_in    = req_tag;
               idx_in    = '0;
               nres_in   = '0;
               pend_v_in = 1'b0;
            end
         end
         OP_TICK:    now_in = now_ff + 1'b1;
         OP_INC_IDX: idx_in = idx_ff + 1'b1;
         OP_SET_POS: begin
            pos_in = idx_ff;
            idx_in = cnt_ff;
         end
         OP_SH_WR:   idx_in = idx_dec;
         OP_PUT:     cnt_in = cnt_ff + 1'b1;
         OP_POP: begin
            if (go) begin
               pend_v_in   = 1'b1;
               pend_tag_in = rd_tag_ff;
               cnt_in      = cnt_ff - 1'b1;
               nres_in     = nres_ff + 1'b1;
               if (head_ff == IDX_W'(DEPTH - 1)) begin
                  head_in = '0;
               end else begin
                  head_in = head_ff + 1'b1;
               end
            end
         end
         OP_EMIT_LAST: begin
            if (go) begin
               pend_v_in = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   // Result register: drop on take, load on an emit
   always_comb begin
      out_v_in    = out_v_ff && !rsp_tready;
      out_kind_in = out_kind_ff;
      out_tag_in  = out_tag_ff;
      out_last_in = out_last_ff;
      if (emit_req && go) begin
         out_v_in = 1'b1;
         case (ctrl.op)
            OP_EMIT_ACC: begin
               out_kind_in = KIND_ACCEPTED;
               out_tag_in  = tag_ff;
               out_last_in = 1'b1;
            end
            OP_EMIT_REJ: begin
               out_kind_in = KIND_REJECTED;
               out_tag_in  = tag_ff;
               out_last_in = 1'b1;
            end
            OP_EMIT_LAST: begin
               out_kind_in = KIND_EXPIRED;
               out_tag_in  = pend_tag_ff;
               out_last_in = 1'b1;
            end
            default: begin
               out_kind_in = KIND_EXPIRED;
               out_tag_in  = pend_tag_ff;
               out_last_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff    <= '0;
         cnt_ff    <= '0;
         head_ff   <= '0;
         idx_ff    <= '0;
         pos_ff    <= '0;
         nres_ff   <= '0;
         act_ff    <= ACT_NONE;
         pend_v_ff <= 1'b0;
         out_v_ff  <= 1'b0;
      end else begin
         now_ff    <= now_in;
         cnt_ff    <= cnt_in;
         head_ff   <= head_in;
         idx_ff    <= idx_in;
         pos_ff    <= pos_in;
         nres_ff   <= nres_in;
         act_ff    <= act_in;
         pend_v_ff <= pend_v_in;
         out_v_ff  <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      dl_ff       <= dl_in;
      tag_ff      <= tag_in;
      pend_tag_ff <= pend_tag_in;
      out_kind_ff <= out_kind_in;
      out_tag_ff  <= out_tag_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_kind   = out_kind_ff;
   assign rsp_tag    = out_tag_ff;
   assign rsp_last   = out_last_ff;

endmodule

// ----- src/deadline_sorted_timer_queue.sv -----
// Deadline sorted timer queue, top level: stream ports, sequencer and datapath.
// Depends on dstq_pkg, dstq_seq and dstq_dp.
//
// Holds up to 16 timeouts sorted earliest deadline first in a circular
// single-port memory, under control of a microcoded sequencer. Each beat on
// req_ is one command: add (deadline = now + delay_ms), tick (now + 1 ms) or
// check (expire due entries, up to 16 per check). An add answers with one
// beat (accepted, or rejected when full); a check answers with one beat per
// expired entry, tlast on the final one; tick and an unused action answer
// with nothing. An add scans the stored entries for its slot, shifts the
// later ones up one place and writes the new one into the freed slot; a
// check reads and pops due head entries in turn. An emit waits while the
// result register is full and rsp_tready is low, and the sequencer holds
// with it. No clearing pass runs after reset.
module deadline_sorted_timer_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [30:0] delay_ms, [46:31] tag, [47] zero
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] tag_res
   output logic [1:0]  rsp_tuser,   // [1:0] kind
   output logic        rsp_tlast
);
   import dstq_pkg::*;

   ctrl_type   ctrl;
   status_type status;

   dstq_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   dstq_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_action (req_tuser),
      .req_delay  (req_tdata[DLY_W-1:0]),
      .req_tag    (req_tdata[DLY_W+TAG_W-1:DLY_W]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_kind   (rsp_tuser),
      .rsp_tag    (rsp_tdata),
      .rsp_last   (rsp_tlast)
   );

endmodule
